@@ design/ftmm_pkg.sv @@
// Shared types and constants of the forward transform matrix multiply block.
// No dependencies; every design file imports this package.
package ftmm_pkg;

  localparam int unsigned AccW = 40;
  localparam int unsigned IdxW = 6;

  typedef struct packed {
    logic               operation;
    logic [5:0]         coef_row;
    logic [5:0]         coef_col;
    logic signed [15:0] coef_value;
    logic signed [15:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] coefficient;
    logic [5:0]         freq_index;
    logic [5:0]         line_index;
    logic               last_of_row;
    logic               last_of_block;
  } out_beat_t;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef struct packed {
    logic            load_we;
    logic            take_sample;
    logic            mac_rd;
    logic            emit_rd;
    logic            load_out;
    logic            clr_valid;
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] col;
    logic [IdxW-1:0] line;
    logic            last_row;
    logic            last_block;
  } dp_cmd_t;

  typedef struct packed {
    logic out_taken;
  } dp_stat_t;

endpackage

@@ design/ftmm_ctrl.sv @@
// Sequencing state machine: row and sample counters, MAC and emit passes.
// Depends on ftmm_pkg; drives the datapath through dp_cmd_t.
module ftmm_ctrl import ftmm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_op_i,
  output logic        in_ready_o,
  input  logic [6:0]  size_i,
  input  logic [6:0]  kept_i,
  input  logic [6:0]  rpb_i,
  input  dp_stat_t    stat_i,
  output dp_cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_DRAIN, S_EMIT_RD, S_EMIT_WAIT, S_OUT
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] r_q, sc_q, row_q;
  logic [6:0]      kept_q;
  logic            rend_q, bend_q, drain_q;
  logic            accept, r_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign r_last     = (({1'b0, r_q} + 7'd1) == kept_q);

  always_comb begin
    cmd_o             = '0;
    cmd_o.idx         = r_q;
    cmd_o.col         = sc_q;
    cmd_o.line        = row_q;
    cmd_o.last_row    = r_last;
    cmd_o.last_block  = r_last && bend_q;
    cmd_o.load_we     = accept && (in_op_i == OpLoad);
    cmd_o.take_sample = accept && (in_op_i == OpSample);
    cmd_o.mac_rd      = (state_q == S_MAC);
    cmd_o.emit_rd     = (state_q == S_EMIT_RD);
    cmd_o.load_out    = (state_q == S_EMIT_WAIT);
    cmd_o.clr_valid   = ((state_q == S_OUT) && stat_i.out_taken && r_last) ||
                        (accept && (in_op_i == OpSample) && (kept_i == 7'd0) &&
                         (({1'b0, sc_q} + 7'd1) >= size_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_q     <= '0;
      sc_q    <= '0;
      row_q   <= '0;
      kept_q  <= '0;
      rend_q  <= 1'b0;
      bend_q  <= 1'b0;
      drain_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept && (in_op_i == OpSample)) begin
            kept_q <= kept_i;
            rend_q <= (({1'b0, sc_q} + 7'd1) >= size_i);
            bend_q <= (({1'b0, row_q} + 7'd1) >= rpb_i);
            r_q    <= '0;
            if (kept_i != 7'd0) begin
              state_q <= S_MAC;
            end else if (({1'b0, sc_q} + 7'd1) >= size_i) begin
              sc_q  <= '0;
              row_q <= (({1'b0, row_q} + 7'd1) >= rpb_i) ? '0 : row_q + 1'b1;
            end else begin
              sc_q <= sc_q + 1'b1;
            end
          end
        end
        S_MAC: begin
          if (r_last) begin
            state_q <= S_DRAIN;
            drain_q <= 1'b0;
          end else begin
            r_q <= r_q + 1'b1;
          end
        end
        S_DRAIN: begin
          drain_q <= 1'b1;
          if (drain_q) begin
            r_q <= '0;
            if (rend_q) begin
              state_q <= S_EMIT_RD;
            end else begin
              sc_q    <= sc_q + 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        S_EMIT_RD:   state_q <= S_EMIT_WAIT;
        S_EMIT_WAIT: state_q <= S_OUT;
        S_OUT: begin
          if (stat_i.out_taken) begin
            if (r_last) begin
              sc_q    <= '0;
              row_q   <= bend_q ? '0 : row_q + 1'b1;
              state_q <= S_IDLE;
            end else begin
              r_q     <= r_q + 1'b1;
              state_q <= S_EMIT_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/ftmm_dp.sv @@
// Datapath: basis memory, accumulator memory with valid bits, shared MAC
// pipeline, rounding shifter and output register. Depends on ftmm_pkg.
module ftmm_dp import ftmm_pkg::*; #(
  parameter int unsigned MAX_SIZE  = 64,
  parameter int unsigned COEF_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_beat_t  in_data_i,
  input  dp_cmd_t   cmd_i,
  input  logic [4:0] shift_i,
  output dp_stat_t  stat_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam int unsigned IW = $clog2(MAX_SIZE);
  localparam int unsigned PW = COEF_BITS + 16;

  logic [COEF_BITS-1:0] basis_q [MAX_SIZE*MAX_SIZE];
  logic [AccW-1:0]      acc_q   [MAX_SIZE];
  logic [MAX_SIZE-1:0]  valid_q;

  logic signed [15:0]          s_q;
  logic signed [COEF_BITS-1:0] b_q;
  logic [AccW-1:0]             a_q, ah_q;
  logic signed [PW-1:0]        prod_q;
  logic                        v1_q, v2_q, out_valid_q;
  logic [IW-1:0]               i1_q, i2_q;
  out_beat_t                   out_q;

  logic              load_ok;
  logic [2*IW-1:0]   wr_addr, rd_addr;
  logic signed [AccW:0] rnd, shd;
  logic [AccW-1:0]   a_eff;
  logic [31:0]       coef;

  assign load_ok = ({1'b0, in_data_i.coef_row} < 7'(MAX_SIZE)) &&
                   ({1'b0, in_data_i.coef_col} < 7'(MAX_SIZE));
  assign wr_addr = {in_data_i.coef_row[IW-1:0], in_data_i.coef_col[IW-1:0]};
  assign rd_addr = {cmd_i.idx[IW-1:0], cmd_i.col[IW-1:0]};

  // Memories and payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && load_ok) begin
      basis_q[wr_addr] <= in_data_i.coef_value[COEF_BITS-1:0];
    end
    if (cmd_i.take_sample) begin
      s_q <= in_data_i.sample;
    end
    if (cmd_i.mac_rd) begin
      b_q <= basis_q[rd_addr];
    end
    if (cmd_i.mac_rd || cmd_i.emit_rd) begin
      a_q <= acc_q[cmd_i.idx[IW-1:0]];
    end
    i1_q   <= cmd_i.idx[IW-1:0];
    i2_q   <= i1_q;
    prod_q <= PW'(s_q * b_q);
    ah_q   <= valid_q[i1_q] ? a_q : '0;
    if (v2_q) begin
      acc_q[i2_q] <= ah_q + AccW'(prod_q);
    end
    if (cmd_i.load_out) begin
      out_q.coefficient   <= coef;
      out_q.freq_index    <= cmd_i.idx;
      out_q.line_index    <= cmd_i.line;
      out_q.last_of_row   <= cmd_i.last_row;
      out_q.last_of_block <= cmd_i.last_block;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_rd;
      v2_q <= v1_q;
      if (cmd_i.clr_valid) begin
        valid_q <= '0;
      end else if (v2_q) begin
        valid_q[i2_q] <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Rounding right shift of the accumulator that was just read.
  always_comb begin
    a_eff = valid_q[cmd_i.idx[IW-1:0]] ? a_q : '0;
    rnd   = $signed({a_eff[AccW-1], a_eff}) +
            ((AccW+1)'(1) << (shift_i - 5'd1));
    shd   = rnd >>> shift_i;
    coef  = (shift_i == 5'd0) ? a_eff[31:0] : shd[31:0];
  end

  assign stat_o.out_taken = out_valid_q && out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

endmodule

@@ design/forward_transform_matrix_multiply.sv @@
// Top level of the forward transform matrix multiply block.
// Depends on ftmm_pkg, ftmm_ctrl and ftmm_dp.
//
// Usage: the input channel carries one beat per item. A beat with operation
// zero writes one basis coefficient. A beat with operation one is the next
// residual sample of the current row; the shared multiply-accumulate unit
// then walks the kept basis rows, one per cycle, and drains its pipeline
// before the next beat is accepted. After the last sample of a row, the
// block emits cutoff result beats, each read from the accumulator memory,
// rounded into the output register and held there until the receiver
// accepts it. The output register holds a beat stable while the receiver
// stalls; no new input beat is taken until the row's results are all
// delivered.
// Configuration is written over the APB port at byte addresses 0, 4, 8 and
// 12 (transform size, cutoff, shift, rows per block) while the block is
// idle. Reset restores the register defaults, clears the counters and the
// accumulator valid bits; the basis memory is undefined until loaded.
module forward_transform_matrix_multiply import ftmm_pkg::*; #(
  parameter int unsigned MAX_SIZE  = 64,
  parameter int unsigned COEF_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_beat_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    REG_SIZE, REG_CUTOFF, REG_SHIFT, REG_RPB
  } reg_e;

  logic [6:0] size_q, cutoff_q, rpb_q;
  logic [4:0] shift_q;
  logic [6:0] size_c, kept_c, rpb_c;
  logic       wr_en;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= 7'd32;
      cutoff_q <= 7'd32;
      shift_q  <= 5'd8;
      rpb_q    <= 7'd32;
    end else if (wr_en) begin
      case (reg_e'(paddr[3:2]))
        REG_SIZE:   size_q   <= pwdata[6:0];
        REG_CUTOFF: cutoff_q <= pwdata[6:0];
        REG_SHIFT:  shift_q  <= pwdata[4:0];
        REG_RPB:    rpb_q    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_SIZE:   prdata = {25'd0, size_q};
      REG_CUTOFF: prdata = {25'd0, cutoff_q};
      REG_SHIFT:  prdata = {27'd0, shift_q};
      REG_RPB:    prdata = {25'd0, rpb_q};
      default:    prdata = '0;
    endcase
  end

  // Zero size and rows per block act as one; everything above the matrix size saturates.
  assign size_c = (size_q == 7'd0) ? 7'd1 :
                  (size_q > 7'(MAX_SIZE)) ? 7'(MAX_SIZE) : size_q;
  assign kept_c = (cutoff_q > 7'(MAX_SIZE)) ? 7'(MAX_SIZE) : cutoff_q;
  assign rpb_c  = (rpb_q == 7'd0) ? 7'd1 :
                  (rpb_q > 7'(MAX_SIZE)) ? 7'(MAX_SIZE) : rpb_q;

  ftmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.operation),
    .in_ready_o (in_ready_o),
    .size_i     (size_c),
    .kept_i     (kept_c),
    .rpb_i      (rpb_c),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ftmm_dp #(
    .MAX_SIZE  (MAX_SIZE),
    .COEF_BITS (COEF_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .shift_i     (shift_q),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Input is never taken while a result beat is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted while a result is pending");

  // The block end only comes with the row end.
  a_block_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_of_block |-> out_data_o.last_of_row)
    else $error("block end without row end");

  // Delivering the last beat of a row returns the block to idle.
  a_row_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last_of_row |=> in_ready_o)
    else $error("block not idle after a finished row");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the forward transform matrix multiply block.
// Depends on ftmm_pkg and the design; a scoreboard class predicts the outputs.
module tb_top;
  import ftmm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxSize = 64;
  localparam logic [3:0] AddrSize = 4'd0;
  localparam logic [3:0] AddrCutoff = 4'd4;
  localparam logic [3:0] AddrShift = 4'd8;
  localparam logic [3:0] AddrRows = 4'd12;

  // Prediction of the transform: it holds its own basis copy, accumulators,
  // counters and registers, and queues the coefficients each row produces.
  class transform_scoreboard;
    logic signed [15:0] basis[MaxSize*MaxSize];
    logic signed [63:0] acc[MaxSize];
    int unsigned sample_idx, row_idx;
    int unsigned size_reg, cutoff_reg, shift_reg, rows_reg;
    out_beat_t pending[$];
    int errors;

    function void reset_state();
      foreach (acc[i]) acc[i] = '0;
      foreach (basis[i]) basis[i] = '0;
      sample_idx = 0;
      row_idx = 0;
      size_reg = 32;
      cutoff_reg = 32;
      shift_reg = 8;
      rows_reg = 32;
      errors = 0;
    endfunction

    function void write_reg(logic [3:0] addr, logic [31:0] value);
      case (addr)
        AddrSize: size_reg = value[6:0];
        AddrCutoff: cutoff_reg = value[6:0];
        AddrShift: shift_reg = value[4:0];
        AddrRows: rows_reg = value[6:0];
        default: ;
      endcase
    endfunction

    function void note_input(in_beat_t b);
      int unsigned size, kept, rpb;
      logic signed [63:0] v;
      logic [63:0] u;
      out_beat_t o;
      logic blk_end;
      if (b.operation == OpLoad) begin
        basis[b.coef_row*MaxSize + b.coef_col] = b.coef_value;
        return;
      end
      size = (size_reg == 0) ? 1 : (size_reg > MaxSize ? MaxSize : size_reg);
      kept = (cutoff_reg > MaxSize) ? MaxSize : cutoff_reg;
      rpb = (rows_reg == 0) ? 1 : (rows_reg > MaxSize ? MaxSize : rows_reg);
      if (sample_idx < MaxSize)
        for (int r = 0; r < kept; r++)
          acc[r] += 64'(b.sample) * 64'(basis[r*MaxSize + sample_idx]);
      if (sample_idx + 1 < size) begin
        sample_idx++;
        return;
      end
      blk_end = (row_idx + 1 >= rpb);
      for (int r = 0; r < kept; r++) begin
        v = acc[r];
        if (shift_reg != 0) v = (v + (64'sd1 <<< (shift_reg - 1))) >>> shift_reg;
        u = v;
        o.coefficient = u[31:0];
        o.freq_index = r[5:0];
        o.line_index = row_idx[5:0];
        o.last_of_row = (r + 1 == kept);
        o.last_of_block = (r + 1 == kept) && blk_end;
        pending.push_back(o);
      end
      foreach (acc[i]) acc[i] = '0;
      sample_idx = 0;
      row_idx = blk_end ? 0 : row_idx + 1;
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.coefficient !== want.coefficient) begin
        $display("%0t: coefficient expected %0d actual %0d", $realtime,
                 want.coefficient, got.coefficient);
        errors++;
      end
      if (got.freq_index !== want.freq_index) begin
        $display("%0t: freq_index expected %0d actual %0d", $realtime,
                 want.freq_index, got.freq_index);
        errors++;
      end
      if (got.line_index !== want.line_index) begin
        $display("%0t: line_index expected %0d actual %0d", $realtime,
                 want.line_index, got.line_index);
        errors++;
      end
      if (got.last_of_row !== want.last_of_row) begin
        $display("%0t: last_of_row expected %b actual %b", $realtime,
                 want.last_of_row, got.last_of_row);
        errors++;
      end
      if (got.last_of_block !== want.last_of_block) begin
        $display("%0t: last_of_block expected %b actual %b", $realtime,
                 want.last_of_block, got.last_of_block);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_beat_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  transform_scoreboard sb = new();
  // When set, the receiver holds off so the block backs up into its input.
  bit hold_off = 1'b0;
  // Beats left in the sender's current burst; at zero a new burst starts after an optional gap.
  int unsigned burst_left = 0;

  always #2 clk_i = ~clk_i;

  forward_transform_matrix_multiply uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Outputs are sampled at the rising edge; each accepted beat is checked.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // Receiver stall pattern: phases of always-ready, random stalls and long
  // runs of stall, plus the long hold-off asked for by the stimulus.
  initial begin
    int unsigned mode;
    int unsigned run;
    forever begin
      mode = $urandom_range(0, 3);
      run = $urandom_range(5, 60);
      repeat (run) begin
        @(negedge clk_i);
        if (hold_off) out_ready_i <= 1'b0;
        else case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= ($urandom_range(0, 1) != 0);
          default: out_ready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Offers one beat at the next falling edge, honoring the sender's
  // burst-and-gap pattern, and returns at the edge that accepts it. Valid
  // stays up after the accepting edge only until the next falling edge,
  // where a following beat replaces the payload or valid is dropped.
  task automatic send_beat(in_beat_t b);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_data_i <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(b);
  endtask

  // Drops valid at the next falling edge once the sender has nothing more.
  task automatic input_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic load_coef(int row, int col, logic signed [15:0] value);
    in_beat_t b;
    b = '0;
    b.operation = OpLoad;
    b.coef_row = row[5:0];
    b.coef_col = col[5:0];
    b.coef_value = value;
    b.sample = 16'($urandom);
    send_beat(b);
  endtask

  task automatic send_sample(logic signed [15:0] value);
    in_beat_t b;
    b.operation = OpSample;
    b.coef_row = 6'($urandom);
    b.coef_col = 6'($urandom);
    b.coef_value = 16'($urandom);
    b.sample = value;
    send_beat(b);
  endtask

  // APB write: a setup phase followed by an access phase.
  task automatic apb_write(logic [3:0] addr, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(addr, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every predicted result has come, then lets the pipeline
  // settle before the registers are touched.
  task automatic drain();
    input_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic configure(int size, int cut, int sh, int rows);
    drain();
    apb_write(AddrSize, size);
    apb_write(AddrCutoff, cut);
    apb_write(AddrShift, sh);
    apb_write(AddrRows, rows);
  endtask

  // Loads the first rows and columns of the basis, either with alternating
  // extremes or with random values. Every entry a row reads is loaded first.
  task automatic load_basis(int rows, int cols, bit extreme);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        load_coef(r, c, extreme ? (((r + c) & 1) ? 16'sh8000 : 16'sh7fff)
                                : 16'($urandom));
  endtask

  task automatic send_rows(int n, int size, int mode);
    for (int i = 0; i < n * size; i++)
      case (mode)
        0: send_sample(16'sh7fff);
        1: send_sample(16'sh8000);
        default: send_sample(16'($urandom));
      endcase
  endtask

  initial begin
    int unsigned sz, ct, rw;
    sb.reset_state();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: extreme basis values and full-scale samples, so the
    // widest dot products and the largest shifts are exercised. Column zero
    // of every basis row is loaded for the saturated cutoff below.
    load_basis(MaxSize, 1, 1'b1);
    load_basis(8, 8, 1'b1);
    configure(8, 4, 1, 2);
    send_rows(1, 8, 0);
    send_rows(1, 8, 1);
    configure(8, 8, 31, 1);
    send_rows(1, 8, 1);
    // Zero size, zero shift and zero rows per block with a cutoff above the
    // range: every sample is a row of its own and all basis rows are kept.
    configure(0, 127, 0, 0);
    send_rows(2, 1, 2);
    // A size above the range saturates; a zero cutoff emits nothing.
    configure(127, 0, 3, 127);
    send_rows(1, 64, 2);
    // A cutoff that is not a multiple of four.
    configure(8, 5, 5, 3);
    // A load outside the kept rows sets an extreme value.
    load_coef(63, 63, 16'sh8000);
    load_coef(0, 0, 16'sh7fff);
    send_rows(1, 8, 2);

    // Random part: fresh random basis, then phases of small transforms
    // interleaved with coefficient reloads.
    configure(8, 8, 8, 4);
    load_basis(8, 10, 1'b0);
    for (int ph = 0; ph < 5; ph++) begin
      sz = $urandom_range(8, 10);
      ct = 4 * $urandom_range(1, 2);
      rw = $urandom_range(1, 4);
      configure(sz, ct, $urandom_range(1, 31), rw);
      for (int k = 0; k < 2; k++) begin
        if ($urandom_range(0, 3) == 0)
          load_coef($urandom_range(0, ct - 1), $urandom_range(0, sz - 1),
                    16'($urandom));
        if (ph == 2 && k == 0) begin
          // Long receiver hold-off while samples keep coming.
          hold_off = 1'b1;
          fork
            begin
              repeat (400) @(negedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        send_rows(1, sz, 2);
      end
    end
    input_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
